### design/pts16_pkg.sv
package pts16_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned RateW   = 16;

  // configuration register indexes
  localparam logic [1:0] CfgSampleWidth = 2'd0;
  localparam logic [1:0] CfgChannelCnt  = 2'd1;
  localparam logic [1:0] CfgSourceRate  = 2'd2;

  localparam logic       WidthByte  = 1'b0;
  localparam logic [1:0] ChanMono   = 2'd1;
  localparam logic [7:0] ByteFlip   = 8'h80;

  localparam logic [RateW-1:0] RateX4A = 16'd8000;
  localparam logic [RateW-1:0] RateX4B = 16'd11025;
  localparam logic [RateW-1:0] RateX4C = 16'd12000;
  localparam logic [RateW-1:0] RateX2A = 16'd16000;
  localparam logic [RateW-1:0] RateX2B = 16'd22050;
  localparam logic [RateW-1:0] RateX2C = 16'd24000;
  localparam logic [RateW-1:0] RateX1A = 16'd32000;
  localparam logic [RateW-1:0] RateX1B = 16'd44100;
  localparam logic [RateW-1:0] RateX1C = 16'd48000;

  typedef struct packed {
    logic             sample_width;
    logic [1:0]       channel_count;
    logic [RateW-1:0] source_rate;
  } cfg_t;

  // repeat count as index of the last frame, plus a flag for a known rate
  typedef struct packed {
    logic       known;
    logic [1:0] last_idx;
  } rep_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
    logic [1:0]                last_idx;
  } frame_t;

  function automatic rep_t rate_rep(logic [RateW-1:0] rate);
    rep_t r;
    r.known    = 1'b1;
    r.last_idx = 2'd0;
    case (rate) inside
      RateX4A, RateX4B, RateX4C: r.last_idx = 2'd3;
      RateX2A, RateX2B, RateX2C: r.last_idx = 2'd1;
      RateX1A, RateX1B, RateX1C: r.last_idx = 2'd0;
      default:                   r.known    = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [SampleW-1:0] conv_sample(logic width, logic [SampleW-1:0] raw);
    logic [SampleW-1:0] s;
    if (width == WidthByte) begin
      s = {raw[7:0] ^ ByteFlip, 8'h00};
    end else begin
      s = raw;
    end
    return s;
  endfunction

endpackage

### design/pts16_if.sv
interface pts16_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_sample;
  logic [15:0] second_sample;

  modport source (output valid, output first_sample, output second_sample, input ready);
  modport sink   (input valid, input first_sample, input second_sample, output ready);
endinterface

interface pts16_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic               last_repeat;

  modport source (output valid, output left_out, output right_out, output last_repeat,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input last_repeat,
                  output ready);
endinterface

### design/pcm_to_stereo16_upsampler_top.sv
// Converts one PCM source frame (8-bit unsigned or 16-bit signed, mono or
// stereo) into 16-bit signed stereo frames, repeated 4, 2 or 1 times for
// source rates of 8/11.025/12, 16/22.05/24 or 32/44.1/48 kHz; any other rate
// yields no output. The input is registered after conversion and a second
// register emits the repeats, one output frame per cycle while the output is
// ready, so the block takes a new input every cycle at repeat 1 when the
// output does not stall; at repeat N a frame enters the second register only
// as the last repeat of the frame before it is taken. Write the configuration
// only while the block is idle.
module pcm_to_stereo16_upsampler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  pts16_in_if.sink    in_i,
  pts16_out_if.source out_o
);
  import pts16_pkg::*;

  cfg_t   cfg_q;
  frame_t frm;
  logic   frm_valid, frm_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_width  <= 1'b1;
      cfg_q.channel_count <= 2'd2;
      cfg_q.source_rate   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSampleWidth: cfg_q.sample_width  <= cfg_wdata_i[0];
        CfgChannelCnt:  cfg_q.channel_count <= cfg_wdata_i[1:0];
        CfgSourceRate:  cfg_q.source_rate   <= cfg_wdata_i[RateW-1:0];
        default: ;
      endcase
    end
  end

  pts16_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .frm_o       (frm),
    .frm_valid_o (frm_valid),
    .frm_ready_i (frm_ready)
  );

  pts16_rep u_rep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frm_i       (frm),
    .frm_valid_i (frm_valid),
    .frm_ready_o (frm_ready),
    .out_o       (out_o)
  );

endmodule

### design/pts16_conv.sv
module pts16_conv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pts16_pkg::cfg_t   cfg_i,
  pts16_in_if.sink          in_i,
  output pts16_pkg::frame_t frm_o,
  output logic              frm_valid_o,
  input  logic              frm_ready_i
);
  import pts16_pkg::*;

  logic   valid_q;
  frame_t frm_q, frm_d;
  rep_t   rep;
  logic   xfer;

  assign in_i.ready = !valid_q || frm_ready_i;
  assign xfer       = in_i.valid && in_i.ready;
  assign rep        = rate_rep(cfg_i.source_rate);

  always_comb begin
    frm_d.left     = conv_sample(cfg_i.sample_width, in_i.first_sample);
    frm_d.right    = (cfg_i.channel_count == ChanMono) ? frm_d.left
                   : conv_sample(cfg_i.sample_width, in_i.second_sample);
    frm_d.last_idx = rep.last_idx;
  end

  // items at an unknown rate are dropped here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (xfer) begin
      valid_q <= rep.known;
    end else if (frm_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      frm_q <= frm_d;
    end
  end

  assign frm_o       = frm_q;
  assign frm_valid_o = valid_q;

endmodule

### design/pts16_rep.sv
module pts16_rep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pts16_pkg::frame_t frm_i,
  input  logic              frm_valid_i,
  output logic              frm_ready_o,
  pts16_out_if.source       out_o
);
  import pts16_pkg::*;

  logic                valid_q;
  logic [1:0]          cnt_q;
  logic [SampleW-1:0]  left_q, right_q;
  logic                out_xfer, last;

  assign last        = (cnt_q == 2'd0);
  assign out_xfer    = valid_q && out_o.ready;
  assign frm_ready_o = !valid_q || (out_o.ready && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 2'd0;
    end else if (frm_valid_i && frm_ready_o) begin
      valid_q <= 1'b1;
      cnt_q   <= frm_i.last_idx;
    end else if (out_xfer) begin
      if (last) begin
        valid_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frm_valid_i && frm_ready_o) begin
      left_q  <= frm_i.left;
      right_q <= frm_i.right;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.left_out    = left_q;
  assign out_o.right_out   = right_q;
  assign out_o.last_repeat = last;

endmodule

### dv/pts16_frame_checker.sv
module pts16_frame_checker
  import pts16_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  pts16_in_if         in_mon,
  pts16_out_if        out_mon,
  output int unsigned pending_o,
  output int unsigned errors_o
);

  typedef struct packed {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
    logic                      last;
  } stereo_frame_t;

  stereo_frame_t    stereo_frames_q[$];
  logic             cur_width;
  logic [1:0]       cur_chans;
  logic [RateW-1:0] cur_rate;
  int unsigned      mismatch_cnt = 0;

  function automatic int unsigned repeat_count(logic [RateW-1:0] rate);
    if (rate == RateX4A || rate == RateX4B || rate == RateX4C) return 4;
    if (rate == RateX2A || rate == RateX2B || rate == RateX2C) return 2;
    if (rate == RateX1A || rate == RateX1B || rate == RateX1C) return 1;
    return 0;
  endfunction

  function automatic logic [SampleW-1:0] to_pcm16(logic [SampleW-1:0] raw);
    if (cur_width == WidthByte) return {raw[7:0] ^ ByteFlip, 8'h00};
    return raw;
  endfunction

  task automatic predict_repeats(logic [SampleW-1:0] first, logic [SampleW-1:0] second);
    stereo_frame_t f;
    int unsigned   reps;
    reps    = repeat_count(cur_rate);
    f.left  = to_pcm16(first);
    // only the value 1 means mono; 0 and 3 behave as stereo
    f.right = (cur_chans == ChanMono) ? f.left : to_pcm16(second);
    for (int unsigned k = 0; k < reps; k++) begin
      f.last = (k + 1 == reps);
      stereo_frames_q.push_back(f);
    end
  endtask

  task automatic check_frame(stereo_frame_t got);
    stereo_frame_t want;
    if (stereo_frames_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("unexpected output frame: L=%h R=%h last=%b", got.left, got.right, got.last);
      end
    end else begin
      want = stereo_frames_q.pop_front();
      if (got.left !== want.left || got.right !== want.right || got.last !== want.last) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("frame mismatch: exp L=%h R=%h last=%b, got L=%h R=%h last=%b",
                   want.left, want.right, want.last, got.left, got.right, got.last);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_width = 1'b1;
      cur_chans = 2'd2;
      cur_rate  = '0;
      stereo_frames_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        check_frame('{left: out_mon.left_out, right: out_mon.right_out,
                      last: out_mon.last_repeat});
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_repeats(in_mon.first_sample, in_mon.second_sample);
      end
      // register write lands after this edge; index 3 is ignored
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSampleWidth: cur_width = cfg_wdata_i[0];
          CfgChannelCnt:  cur_chans = cfg_wdata_i[1:0];
          CfgSourceRate:  cur_rate  = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    pending_o <= stereo_frames_q.size();
    errors_o  <= mismatch_cnt;
  end

endmodule

### dv/testbench.sv
module testbench;
  import pts16_pkg::*;

  localparam logic        WidthWord   = 1'b1;
  localparam logic [1:0]  ChanStereo  = 2'd2;
  localparam logic [1:0]  ChanOddLo   = 2'd0;
  localparam logic [1:0]  ChanOddHi   = 2'd3;
  localparam logic [1:0]  CfgNone     = 2'd3;
  localparam int unsigned IdlePct     = 34;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned RandItems   = 80;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_idx   = '0;
  logic [15:0] cfg_wdata = '0;
  logic        steady    = 1'b0;
  int unsigned hold_seq  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned pending;
  int unsigned errors;

  logic [RateW-1:0] known_rates [9] = '{RateX4A, RateX4B, RateX4C, RateX2A, RateX2B,
                                        RateX2C, RateX1A, RateX1B, RateX1C};

  pts16_in_if  in_if ();
  pts16_out_if out_if ();

  always #2 clk_i = ~clk_i;

  pcm_to_stereo16_upsampler_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  pts16_frame_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // no transfer on either side for too long means the block is stuck
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // output side: random back-pressure, plus long holds on request
  initial begin
    int unsigned hold_left;
    int unsigned holds_seen;
    hold_left     = 0;
    holds_seen    = 0;
    out_if.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != holds_seen) begin
        holds_seen = hold_seq;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = steady || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  task automatic send_frame(logic [15:0] first, logic [15:0] second);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_if.valid         = 1'b0;
      in_if.first_sample  = 16'($urandom);
      in_if.second_sample = 16'($urandom);
      @(negedge clk_i);
    end
    in_if.valid         = 1'b1;
    in_if.first_sample  = first;
    in_if.second_sample = second;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // stop offering and let every outstanding frame drain out
  task automatic drain;
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk_i);
  endtask

  // unused upper data bits are random, the block must mask them
  task automatic set_mode(logic width, logic [1:0] chans, logic [RateW-1:0] rate);
    drain;
    write_reg(CfgSampleWidth, {15'($urandom), width});
    write_reg(CfgChannelCnt, {14'($urandom), chans});
    write_reg(CfgSourceRate, rate);
    cfg_we = 1'b0;
  endtask

  initial begin
    int unsigned      sent;
    int unsigned      phase;
    int unsigned      n_items;
    int unsigned      pick;
    logic [1:0]       chans;
    logic [RateW-1:0] rate;

    in_if.valid         = 1'b0;
    in_if.first_sample  = '0;
    in_if.second_sample = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset rate is zero: nothing comes out
    send_frame(16'h1234, 16'h5678);

    set_mode(WidthWord, ChanStereo, RateX4A);
    send_frame(16'h0000, 16'hFFFF);
    send_frame(16'hFFFF, 16'h0000);
    send_frame(16'h8000, 16'h7FFF);

    set_mode(WidthWord, ChanMono, RateX2B);
    send_frame(16'h7FFF, 16'h8000);

    // byte mode ignores the high byte
    set_mode(WidthByte, ChanStereo, RateX2A);
    send_frame(16'hFF00, 16'h00FF);
    send_frame(16'h0080, 16'h007F);
    send_frame(16'hAB7F, 16'hCD80);

    set_mode(WidthByte, ChanMono, RateX1C);
    send_frame(16'h12FF, 16'hFFFF);

    set_mode(WidthWord, ChanOddLo, RateX1A);
    send_frame(16'hCAFE, 16'hBEEF);
    set_mode(WidthByte, ChanOddHi, RateX4C);
    send_frame(16'h5501, 16'hAAFE);

    set_mode(WidthWord, ChanStereo, 16'd47999);
    send_frame(16'h0001, 16'hFFFE);
    set_mode(WidthWord, ChanStereo, 16'hFFFF);
    send_frame(16'hFFFE, 16'h0001);

    // a write past the last register must change nothing
    set_mode(WidthWord, ChanStereo, RateX2C);
    write_reg(CfgNone, 16'($urandom));
    cfg_we = 1'b0;
    send_frame(16'($urandom), 16'($urandom));

    foreach (known_rates[i]) begin
      set_mode(1'($urandom), ChanStereo, known_rates[i]);
      send_frame(16'($urandom), 16'($urandom));
    end

    sent  = 0;
    phase = 0;
    while (sent < RandItems) begin
      pick = $urandom_range(99);
      if (pick < 40) chans = ChanMono;
      else if (pick < 90) chans = ChanStereo;
      else if (pick < 95) chans = ChanOddLo;
      else chans = ChanOddHi;
      if ($urandom_range(99) < 85) rate = known_rates[$urandom_range(8)];
      else rate = 16'($urandom);
      // first phases: deepest repeat, for the hold-off and the no-idle stretch
      if (phase <= 2) rate = RateX4B;
      set_mode(1'($urandom), chans, rate);
      steady = (phase == 2);
      if (phase == 1) hold_seq++;
      n_items = $urandom_range(8, 20);
      repeat (n_items) send_frame(16'($urandom), 16'($urandom));
      sent += n_items;
      phase++;
    end

    drain;
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
design/pts16_pkg.sv
design/pts16_if.sv
design/pts16_conv.sv
design/pts16_rep.sv
design/pcm_to_stereo16_upsampler_top.sv
dv/pts16_frame_checker.sv
dv/testbench.sv
